@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property with a non-overlapping implication from antecedent to consequent.
`define CSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cordic_sc_pkg.sv @@
package cordic_sc_pkg;

    // Field and datapath widths.
    localparam int AngleWidth        = 27;
    localparam int VecWidth          = 20;
    localparam int OutWidth          = 18;
    localparam int MaxIterations     = 24;
    localparam int DefaultIterations = 24;
    localparam int AtanIndexWidth    = 5;

    typedef logic signed [AngleWidth-1:0] angle_t;
    typedef logic signed [VecWidth-1:0]   vec_t;
    typedef logic signed [OutWidth-1:0]   result_t;

    // Angle constants in degrees, signed Q10.16.
    localparam angle_t Ang90     = 27'sd5898240;
    localparam angle_t Ang180    = 27'sd11796480;
    localparam angle_t Ang270    = 27'sd17694720;
    localparam angle_t Ang360    = 27'sd23592960;
    localparam angle_t NegAng360 = -27'sd23592960;
    localparam angle_t AngZero   = 27'sd0;

    // Starting vector length: the inverse of the CORDIC gain.
    localparam vec_t StartX = 20'sd39797;
    localparam vec_t VecZero = 20'sd0;

    // State of one item on its way through the rotation stages.
    typedef struct packed {
        angle_t angle;
        angle_t acc;
        vec_t   x;
        vec_t   y;
        logic   negate;
    } rotor_t;

    // Arctangent of 2^-i in degrees, signed Q10.16.
    function automatic angle_t atan_deg(input logic [AtanIndexWidth-1:0] idx);
        angle_t val;
        case (idx)
            5'd0:    val = 27'sd2949120;
            5'd1:    val = 27'sd1740967;
            5'd2:    val = 27'sd919879;
            5'd3:    val = 27'sd466945;
            5'd4:    val = 27'sd234379;
            5'd5:    val = 27'sd117304;
            5'd6:    val = 27'sd58666;
            5'd7:    val = 27'sd29335;
            5'd8:    val = 27'sd14668;
            5'd9:    val = 27'sd7334;
            5'd10:   val = 27'sd3667;
            5'd11:   val = 27'sd1833;
            5'd12:   val = 27'sd917;
            5'd13:   val = 27'sd458;
            5'd14:   val = 27'sd229;
            5'd15:   val = 27'sd115;
            5'd16:   val = 27'sd57;
            5'd17:   val = 27'sd29;
            5'd18:   val = 27'sd14;
            5'd19:   val = 27'sd7;
            5'd20:   val = 27'sd4;
            5'd21:   val = 27'sd2;
            5'd22:   val = 27'sd1;
            default: val = 27'sd0;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/cordic_sc_angle_if.sv @@
interface cordic_sc_angle_if;
    logic                  valid;
    logic                  ready;
    cordic_sc_pkg::angle_t angle_deg_q16;

    modport source (output valid, output angle_deg_q16, input ready);
    modport sink (input valid, input angle_deg_q16, output ready);
endinterface

@@ rtl/cordic_sc_result_if.sv @@
interface cordic_sc_result_if;
    logic                   valid;
    logic                   ready;
    cordic_sc_pkg::result_t sine_q16;
    cordic_sc_pkg::result_t cosine_q16;

    modport source (output valid, output sine_q16, output cosine_q16, input ready);
    modport sink (input valid, input sine_q16, input cosine_q16, output ready);
endinterface

@@ rtl/cordic_sc_stage.sv @@
module cordic_sc_stage #(
    parameter int STAGE = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  valid_in,
    input  cordic_sc_pkg::rotor_t data_in,
    output logic                  valid_out,
    output cordic_sc_pkg::rotor_t data_out
);

    localparam logic [cordic_sc_pkg::AtanIndexWidth-1:0] StageIdx =
        cordic_sc_pkg::AtanIndexWidth'(STAGE);
    localparam cordic_sc_pkg::angle_t StageAtan = cordic_sc_pkg::atan_deg(StageIdx);

    cordic_sc_pkg::vec_t   x_in;
    cordic_sc_pkg::vec_t   y_in;
    cordic_sc_pkg::vec_t   x_shift;
    cordic_sc_pkg::vec_t   y_shift;
    cordic_sc_pkg::rotor_t data_next;
    cordic_sc_pkg::rotor_t data_reg;
    logic                  valid_reg;

    // One micro-rotation: turn towards the target angle by atan(2^-STAGE).
    always_comb
    begin
        x_in      = data_in.x;
        y_in      = data_in.y;
        x_shift   = x_in >>> STAGE;
        y_shift   = y_in >>> STAGE;
        data_next = data_in;
        if (data_in.acc < data_in.angle)
        begin
            data_next.x   = x_in - y_shift;
            data_next.y   = y_in + x_shift;
            data_next.acc = data_in.acc + StageAtan;
        end
        else
        begin
            data_next.x   = x_in + y_shift;
            data_next.y   = y_in - x_shift;
            data_next.acc = data_in.acc - StageAtan;
        end
    end

    // Valid bit; it moves only when the pipeline advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ rtl/cordic_sine_cosine_core.sv @@
// Channel   Modport  Payload                       Role
// angle_ch  sink     angle_deg_q16 (27 b, signed)  angle in degrees, Q10.16
// result_ch source   sine_q16, cosine_q16 (18 b)   sine and cosine, Q1.16
//
// One transfer is taken every cycle while the pipeline is not stalled.
// The path holds one register stage per CORDIC micro-rotation, plus two
// stages of angle reduction and one output register.
// Reset clears all valid bits; payload registers are not reset.
// When a result waits untaken, the whole pipeline holds and angle_ch.ready falls.
`include "assert_macros.svh"

module cordic_sine_cosine_core #(
    parameter int ITERATIONS = cordic_sc_pkg::DefaultIterations
) (
    input  logic                      clk,
    input  logic                      rst_n,
    cordic_sc_angle_if.sink           angle_ch,
    cordic_sc_result_if.source        result_ch
);

    logic                  advance;

    logic                  pre_a_valid_reg;
    cordic_sc_pkg::angle_t pre_a_angle_reg;
    cordic_sc_pkg::angle_t pre_a_angle_next;
    cordic_sc_pkg::angle_t reduced;

    logic                  pre_b_valid_reg;
    cordic_sc_pkg::rotor_t pre_b_data_reg;
    cordic_sc_pkg::rotor_t pre_b_data_next;

    logic [ITERATIONS:0]   stage_valid;
    cordic_sc_pkg::rotor_t stage_data [ITERATIONS+1];

    cordic_sc_pkg::rotor_t last;
    cordic_sc_pkg::vec_t   x_fin;
    cordic_sc_pkg::vec_t   y_fin;
    logic                  out_valid_reg;
    cordic_sc_pkg::result_t sine_reg;
    cordic_sc_pkg::result_t cosine_reg;

    logic                  angle_take;
    logic                  start_angle_ok;

    // The pipeline moves whenever the output register is free or being emptied.
    assign advance        = !out_valid_reg || result_ch.ready;
    assign angle_ch.ready = advance;

    // First stage: remove one turn, then move negative angles up by a turn.
    always_comb
    begin
        if (angle_ch.angle_deg_q16 >= cordic_sc_pkg::Ang360)
        begin
            reduced = angle_ch.angle_deg_q16 - cordic_sc_pkg::Ang360;
        end
        else if (angle_ch.angle_deg_q16 <= cordic_sc_pkg::NegAng360)
        begin
            reduced = angle_ch.angle_deg_q16 + cordic_sc_pkg::Ang360;
        end
        else
        begin
            reduced = angle_ch.angle_deg_q16;
        end
        if (reduced < cordic_sc_pkg::AngZero)
        begin
            pre_a_angle_next = reduced + cordic_sc_pkg::Ang360;
        end
        else
        begin
            pre_a_angle_next = reduced;
        end
    end

    // Second stage: pick the starting angle by quadrant and the sign flip.
    always_comb
    begin
        pre_b_data_next.angle = pre_a_angle_reg;
        pre_b_data_next.x     = cordic_sc_pkg::StartX;
        pre_b_data_next.y     = cordic_sc_pkg::VecZero;
        if (pre_a_angle_reg > cordic_sc_pkg::Ang270)
        begin
            pre_b_data_next.acc = cordic_sc_pkg::Ang360;
        end
        else if (pre_a_angle_reg > cordic_sc_pkg::Ang90)
        begin
            pre_b_data_next.acc = cordic_sc_pkg::Ang180;
        end
        else
        begin
            pre_b_data_next.acc = cordic_sc_pkg::AngZero;
        end
        // Angles above 90 and up to and including 270 degrees are negated.
        pre_b_data_next.negate = (pre_a_angle_reg > cordic_sc_pkg::Ang90) &&
                                 (pre_a_angle_reg <= cordic_sc_pkg::Ang270);
    end

    // Valid bits of the two reduction stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_a_valid_reg <= 1'b0;
            pre_b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            pre_a_valid_reg <= angle_ch.valid;
            pre_b_valid_reg <= pre_a_valid_reg;
        end
    end

    // Payload of the two reduction stages.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pre_a_angle_reg <= pre_a_angle_next;
            pre_b_data_reg  <= pre_b_data_next;
        end
    end

    assign stage_valid[0] = pre_b_valid_reg;
    assign stage_data[0]  = pre_b_data_reg;

    // One registered micro-rotation per stage.
    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_stage
        cordic_sc_stage #(
            .STAGE (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (stage_valid[i]),
            .data_in   (stage_data[i]),
            .valid_out (stage_valid[i+1]),
            .data_out  (stage_data[i+1])
        );
    end

    // Apply the sign flip; the output register truncates to the result width.
    always_comb
    begin
        last = stage_data[ITERATIONS];
        if (last.negate)
        begin
            x_fin = -last.x;
            y_fin = -last.y;
        end
        else
        begin
            x_fin = last.x;
            y_fin = last.y;
        end
    end

    // Output register valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_valid[ITERATIONS];
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sine_reg   <= y_fin[cordic_sc_pkg::OutWidth-1:0];
            cosine_reg <= x_fin[cordic_sc_pkg::OutWidth-1:0];
        end
    end

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.sine_q16   = sine_reg;
    assign result_ch.cosine_q16 = cosine_reg;

    // Conditions watched by the checks below.
    assign angle_take     = angle_ch.valid && advance;
    assign start_angle_ok = !pre_b_valid_reg ||
                            (pre_b_data_reg.acc == cordic_sc_pkg::AngZero) ||
                            (pre_b_data_reg.acc == cordic_sc_pkg::Ang180) ||
                            (pre_b_data_reg.acc == cordic_sc_pkg::Ang360);

    // A stall freezes every valid bit in the rotation pipeline.
    `CSC_ASSERT_NEXT(a_stall_holds, clk, rst_n, !advance, $stable(stage_valid), "stage moved")

    // An accepted transfer always lands in the first reduction stage.
    `CSC_ASSERT_NEXT(a_accept_lands, clk, rst_n, angle_take, pre_a_valid_reg, "transfer lost")

    // The starting angle is always one of the three quadrant bases.
    `CSC_ASSERT(a_start_angle, clk, rst_n, start_angle_ok, "bad start angle")

endmodule
